/* rtl/kwm_pkg.sv */
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared sizes, payload types and codes for the k-way merge engine.
// ----------------------------------------------------------------------------
package kwm_pkg;

    // Sizes of the merge engine.
    localparam int MAX_LISTS  = 8;
    localparam int LIST_DEPTH = 64;

    // Fixed widths of the request and result fields.
    localparam int VALUE_W    = 32;
    localparam int LIST_IDX_W = 3;
    localparam int CFG_W      = 4;

    // Derived widths.
    localparam int LIST_W     = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1;
    localparam int PTR_W      = $clog2(2 * LIST_DEPTH);
    localparam int ADDR_W     = $clog2(MAX_LISTS * LIST_DEPTH);
    localparam int NUM_W      = $clog2(MAX_LISTS + 1);

    // Reset value of the lists-in-use register.
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

    typedef enum logic
    {
        MODE_PUSH = 1'b0,
        MODE_POP  = 1'b1
    } mode_t;

    typedef enum logic [1:0]
    {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_BAD_INDEX = 2'd2,
        STAT_EMPTY     = 2'd3
    } status_t;

    typedef enum logic
    {
        S_IDLE   = 1'b0,
        S_REFILL = 1'b1
    } state_t;

    // One request.
    typedef struct packed
    {
        mode_t                     mode;
        logic [LIST_IDX_W-1:0]     list_index;
        logic signed [VALUE_W-1:0] value;
    } item_t;

    // One result.
    typedef struct packed
    {
        logic signed [VALUE_W-1:0] out_value;
        logic [LIST_IDX_W-1:0]     out_list;
        status_t                   status;
    } result_t;

    // Outcome of the head comparison.
    typedef struct packed
    {
        logic                      found;
        logic [LIST_W-1:0]         idx;
        logic signed [VALUE_W-1:0] val;
    } cand_t;

    // Pointer advance, counting modulo twice the list depth.
    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(2 * LIST_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // Fill level of a list from its two pointers.
    function automatic logic [PTR_W-1:0] ptr_fill(input logic [PTR_W-1:0] wr,
                                                  input logic [PTR_W-1:0] rd);
        return (wr >= rd) ? wr - rd : PTR_W'(int'(wr) + 2 * LIST_DEPTH - int'(rd));
    endfunction

    // Store address of a pointer within a list.
    function automatic logic [ADDR_W-1:0] slot_addr(input logic [LIST_W-1:0] k,
                                                    input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] off;
        off = (p >= PTR_W'(LIST_DEPTH)) ? p - PTR_W'(LIST_DEPTH) : p;
        return ADDR_W'(int'(k) * LIST_DEPTH + int'(off));
    endfunction

endpackage

/* rtl/k_way_merge_engine.sv */
// ----------------------------------------------------------------------------
// k_way_merge_engine
// Merges bounded per-list FIFOs into one ascending, stable output stream.
// ----------------------------------------------------------------------------
// Usage:
// A request is taken at a rising edge with start high and busy low. A push
// appends item.value to list item.list_index; a pop removes the smallest head
// among the lists in use and returns it with its list number.
// Every request gives one result, shown on result for exactly one cycle with
// done high, in the cycle after the request was taken. The receiver cannot
// stall the block.
// A push never raises busy. A pop raises busy while the new head is fetched
// from the list store (one read port, registered read) when its list still
// holds data; otherwise it leaves busy low.
// The heads of all lists sit in registers, so the comparison needs no memory
// access. The user writes lists-in-use through cfg_valid/cfg_ready (always
// ready) only while no request is in flight; the block does not enforce it.
// Reset empties every list and sets lists in use to eight; the list store
// itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module k_way_merge_engine
    import kwm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  item_t            item,
    output logic             done,
    output result_t          result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    // Registers.
    logic [CFG_W-1:0]          cfg_reg;
    logic [PTR_W-1:0]          rd_ptr_reg [MAX_LISTS];
    logic [PTR_W-1:0]          rd_ptr_next [MAX_LISTS];
    logic [PTR_W-1:0]          wr_ptr_reg [MAX_LISTS];
    logic [PTR_W-1:0]          wr_ptr_next [MAX_LISTS];
    logic signed [VALUE_W-1:0] head_reg [MAX_LISTS];
    state_t                    state_reg;
    state_t                    state_next;
    logic [LIST_W-1:0]         refill_list_reg;
    logic [LIST_W-1:0]         refill_list_next;
    logic                      done_reg;
    logic                      done_next;
    result_t                   result_reg;
    result_t                   result_next;

    // Combinational signals.
    logic                      accept;
    logic                      is_pop;
    logic [NUM_W-1:0]          num_lists;
    logic [PTR_W-1:0]          fill [MAX_LISTS];
    logic [MAX_LISTS-1:0]      eligible;
    cand_t                     winner;
    logic [LIST_W-1:0]         push_idx;
    logic                      push_bad;
    logic                      push_full;
    logic                      push_empty;
    logic                      refill_needed;
    logic [PTR_W-1:0]          rd_after;
    logic                      head_we;
    logic [LIST_W-1:0]         head_sel;
    logic signed [VALUE_W-1:0] head_data;
    logic                      ram_we;
    logic [ADDR_W-1:0]         ram_addr;
    logic [VALUE_W-1:0]        ram_rdata;

    assign accept    = start && !busy;
    assign is_pop    = (item.mode == MODE_POP);
    assign cfg_ready = 1'b1;

    // Effective number of lists: zero acts as one, large values clamp.
    always_comb
    begin
        if (cfg_reg == '0)
        begin
            num_lists = NUM_W'(1);
        end
        else if (int'(cfg_reg) > MAX_LISTS)
        begin
            num_lists = NUM_W'(MAX_LISTS);
        end
        else
        begin
            num_lists = NUM_W'(cfg_reg);
        end
    end

    // Fill levels and the lists that take part in a pop.
    always_comb
    begin
        for (int k = 0; k < MAX_LISTS; k++)
        begin
            fill[k]     = ptr_fill(wr_ptr_reg[k], rd_ptr_reg[k]);
            eligible[k] = (fill[k] != '0) && (k < int'(num_lists));
        end
    end

    kwm_min_tree u_min_tree (
        .heads    (head_reg),
        .eligible (eligible),
        .winner   (winner)
    );

    // Push checks: index range first, then space in the list.
    assign push_idx      = LIST_W'(int'(item.list_index));
    assign push_bad      = int'(item.list_index) >= int'(num_lists);
    assign push_full     = (fill[push_idx] == PTR_W'(LIST_DEPTH));
    assign push_empty    = (fill[push_idx] == '0);
    assign rd_after      = ptr_next(rd_ptr_reg[winner.idx]);
    assign refill_needed = (fill[winner.idx] > PTR_W'(1));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && is_pop && winner.found && refill_needed)
                begin
                    state_next = S_REFILL;
                end
            end
            S_REFILL:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State-dependent outputs: busy flag and the head refill.
    always_comb
    begin
        busy      = 1'b0;
        head_we   = 1'b0;
        head_sel  = push_idx;
        head_data = item.value;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && !is_pop && !push_bad && !push_full && push_empty)
                begin
                    head_we = 1'b1;
                end
            end
            S_REFILL:
            begin
                busy      = 1'b1;
                head_we   = 1'b1;
                head_sel  = refill_list_reg;
                head_data = $signed(ram_rdata);
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    // Request datapath: pointer updates, store access and the result.
    always_comb
    begin
        rd_ptr_next      = rd_ptr_reg;
        wr_ptr_next      = wr_ptr_reg;
        refill_list_next = refill_list_reg;
        done_next        = accept;
        result_next      = '0;
        ram_we           = 1'b0;
        ram_addr         = slot_addr(winner.idx, rd_after);
        if (accept)
        begin
            if (is_pop)
            begin
                if (winner.found)
                begin
                    rd_ptr_next[winner.idx] = rd_after;
                    refill_list_next        = winner.idx;
                    result_next.out_value   = winner.val;
                    result_next.out_list    = LIST_IDX_W'(int'(winner.idx));
                    result_next.status      = STAT_OK;
                end
                else
                begin
                    result_next.status = STAT_EMPTY;
                end
            end
            else
            begin
                priority if (push_bad)
                begin
                    result_next.status = STAT_BAD_INDEX;
                end
                else if (push_full)
                begin
                    result_next.status = STAT_FULL;
                end
                else
                begin
                    ram_we                = 1'b1;
                    ram_addr              = slot_addr(push_idx, wr_ptr_reg[push_idx]);
                    wr_ptr_next[push_idx] = ptr_next(wr_ptr_reg[push_idx]);
                    result_next.status    = STAT_OK;
                end
            end
        end
    end

    kwm_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_LISTS * LIST_DEPTH)
    ) u_list_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (item.value),
        .rdata (ram_rdata)
    );

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg   <= CFG_RESET;
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            for (int k = 0; k < MAX_LISTS; k++)
            begin
                rd_ptr_reg[k] <= '0;
                wr_ptr_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cfg_reg <= cfg_data;
            end
            state_reg  <= state_next;
            done_reg   <= done_next;
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
        end
    end

    // Payload registers: list heads, refill target and the result.
    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_reg[head_sel] <= head_data;
        end
        refill_list_reg <= refill_list_next;
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* rtl/kwm_ram.sv */
// ----------------------------------------------------------------------------
// kwm_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module kwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write on request; read data is registered every cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* rtl/kwm_min_tree.sv */
// ----------------------------------------------------------------------------
// kwm_min_tree
// Tournament over the list heads: smallest eligible head, lowest index on ties.
// ----------------------------------------------------------------------------
module kwm_min_tree
    import kwm_pkg::*;
(
    input  logic signed [VALUE_W-1:0] heads [MAX_LISTS],
    input  logic [MAX_LISTS-1:0]      eligible,
    output cand_t                     winner
);

    localparam int LEAVES = 2 ** LIST_W;

    cand_t lvl [LIST_W+1][LEAVES];

    // Each level halves the field; the left entry wins unless the right is
    // strictly smaller, which keeps the lowest list index on equal values.
    always_comb
    begin
        for (int l = 0; l <= LIST_W; l++)
        begin
            for (int i = 0; i < LEAVES; i++)
            begin
                lvl[l][i] = '0;
            end
        end
        for (int i = 0; i < LEAVES; i++)
        begin
            if (i < MAX_LISTS)
            begin
                lvl[0][i].found = eligible[i];
                lvl[0][i].idx   = LIST_W'(i);
                lvl[0][i].val   = heads[i];
            end
        end
        for (int l = 0; l < LIST_W; l++)
        begin
            for (int j = 0; j < (LEAVES >> (l + 1)); j++)
            begin
                if (lvl[l][2*j+1].found &&
                    (!lvl[l][2*j].found || (lvl[l][2*j+1].val < lvl[l][2*j].val)))
                begin
                    lvl[l+1][j] = lvl[l][2*j+1];
                end
                else
                begin
                    lvl[l+1][j] = lvl[l][2*j];
                end
            end
        end
    end

    assign winner = lvl[LIST_W][0];

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the k-way merge engine: push and pop requests are
// driven in random bursts, each result is predicted by a behavioural model of
// the bounded lists, and every result is compared field by field.
// ----------------------------------------------------------------------------
module testbench;

    import kwm_pkg::*;

    // Kinds of entry in the queue of pending stimulus.
    typedef enum
    {
        ENTRY_REQUEST,
        ENTRY_CONFIG,
        ENTRY_DRAIN
    } entry_kind_t;

    typedef struct
    {
        entry_kind_t      kind;
        item_t            req;
        logic [CFG_W-1:0] cfg;
    } stim_entry_t;

    // A predicted result and the time its request was taken.
    typedef struct
    {
        result_t res;
        longint  stamp;
    } merge_due_t;

    localparam longint RUN_LIMIT = 64'd8 * 64'd200000;

    // Block ports.
    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             start     = 1'b0;
    logic             busy;
    item_t            item      = '0;
    logic             done;
    result_t          result;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data  = '0;

    // Stimulus and expected results.
    stim_entry_t request_queue[$];
    merge_due_t  merge_results_due[$];
    int          mismatches = 0;

    // Predicted contents of the lists and of the lists-in-use register.
    logic signed [VALUE_W-1:0] list_mem [MAX_LISTS][LIST_DEPTH];
    int                        rd_ptr [MAX_LISTS] = '{default: 0};
    int                        wr_ptr [MAX_LISTS] = '{default: 0};
    logic [CFG_W-1:0]          lists_cfg = CFG_RESET;

    // Sender pacing.
    int burst_left = 1;
    int idle_left  = 0;

    k_way_merge_engine u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // Pointers count modulo twice the list depth.
    function automatic int wrap_inc(input int p);
        return (p + 1) % (2 * LIST_DEPTH);
    endfunction

    function automatic int list_fill(input int k);
        return (wr_ptr[k] - rd_ptr[k] + 2 * LIST_DEPTH) % (2 * LIST_DEPTH);
    endfunction

    // Applies one request to the predicted lists and returns its result.
    function automatic result_t merge_step(input item_t req);
        result_t                   r;
        int                        n;
        int                        idx;
        int                        best;
        bit                        found;
        logic signed [VALUE_W-1:0] best_val;
        logic signed [VALUE_W-1:0] head_val;
        r.out_value = '0;
        r.out_list  = '0;
        r.status    = STAT_OK;
        // A register value of zero acts as one, anything above the maximum as the maximum.
        if (lists_cfg == '0)
            n = 1;
        else if (int'(lists_cfg) > MAX_LISTS)
            n = MAX_LISTS;
        else
            n = int'(lists_cfg);
        idx      = int'(req.list_index);
        found    = 1'b0;
        best     = 0;
        best_val = '0;
        if (req.mode == MODE_PUSH)
        begin
            // The index check comes before the full check.
            if (idx >= n)
                r.status = STAT_BAD_INDEX;
            else if (list_fill(idx) >= LIST_DEPTH)
                r.status = STAT_FULL;
            else
            begin
                list_mem[idx][wr_ptr[idx] % LIST_DEPTH] = req.value;
                wr_ptr[idx] = wrap_inc(wr_ptr[idx]);
            end
        end
        else
        begin
            // Strict less-than keeps the lowest list index on equal heads.
            for (int k = 0; k < n; k++)
            begin
                if (list_fill(k) != 0)
                begin
                    head_val = list_mem[k][rd_ptr[k] % LIST_DEPTH];
                    if (!found || head_val < best_val)
                    begin
                        found    = 1'b1;
                        best     = k;
                        best_val = head_val;
                    end
                end
            end
            if (!found)
                r.status = STAT_EMPTY;
            else
            begin
                rd_ptr[best] = wrap_inc(rd_ptr[best]);
                r.out_value  = best_val;
                r.out_list   = LIST_IDX_W'(best);
            end
        end
        return r;
    endfunction

    task automatic queue_request(input mode_t m, input int idx, input logic [VALUE_W-1:0] v);
        stim_entry_t e;
        e.kind            = ENTRY_REQUEST;
        e.req.mode        = m;
        e.req.list_index  = LIST_IDX_W'(idx);
        e.req.value       = v;
        e.cfg             = '0;
        request_queue.push_back(e);
    endtask

    task automatic queue_cfg(input int v);
        stim_entry_t e;
        e.kind = ENTRY_CONFIG;
        e.req  = '0;
        e.cfg  = CFG_W'(v);
        request_queue.push_back(e);
    endtask

    // Driver: takes requests from the pending queue in bursts and predicts
    // each result at the edge where the request is taken.
    always @(posedge clk)
    begin : request_driver
        logic       nxt_start;
        logic       nxt_cfg;
        merge_due_t due;
        if (rst_n)
        begin
            nxt_start = start;
            nxt_cfg   = cfg_valid;
            if (start && !busy)
            begin
                due.res   = merge_step(item);
                due.stamp = $time;
                merge_results_due.push_back(due);
                nxt_start = 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                lists_cfg = cfg_data;
                nxt_cfg   = 1'b0;
            end
            if (!nxt_start && !nxt_cfg && request_queue.size() != 0)
            begin
                if (idle_left != 0)
                    idle_left--;
                else if (request_queue[0].kind == ENTRY_REQUEST)
                begin
                    item      <= request_queue[0].req;
                    nxt_start = 1'b1;
                    void'(request_queue.pop_front());
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 40);
                        idle_left  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left--;
                end
                // Register writes and pauses wait until the block is idle and
                // every outstanding result has been seen.
                else if (!start && !busy && !done && merge_results_due.size() == 0)
                begin
                    if (request_queue[0].kind == ENTRY_CONFIG)
                    begin
                        cfg_data <= request_queue[0].cfg;
                        nxt_cfg  = 1'b1;
                    end
                    void'(request_queue.pop_front());
                end
            end
            start     <= nxt_start;
            cfg_valid <= nxt_cfg;
        end
    end

    // Monitor: compares each result with the oldest prediction. A prediction
    // made at this very edge cannot have produced a result yet.
    always @(posedge clk)
    begin : result_check
        merge_due_t due;
        if (rst_n && done)
        begin
            if (merge_results_due.size() == 0 || merge_results_due[0].stamp == $time)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result at %0t: value %h list %0d status %0d",
                             $time, result.out_value, result.out_list, result.status);
            end
            else
            begin
                due = merge_results_due.pop_front();
                if (result.out_value !== due.res.out_value ||
                    result.out_list !== due.res.out_list ||
                    result.status !== due.res.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch at %0t: expected %h/%0d/%0d, got %h/%0d/%0d",
                                 $time, due.res.out_value, due.res.out_list,
                                 due.res.status, result.out_value, result.out_list,
                                 result.status);
                end
            end
        end
    end

    // Stimulus: a directed opening, then phases of random bursts, each phase
    // under its own lists-in-use setting.
    initial
    begin : stimulus
        int          cfg_plan [10];
        int          run_val [MAX_LISTS];
        int          shared_val;
        int          gen_n;
        int          left;
        int          len;
        int          push_pct;
        int          k;
        logic [31:0] v;
        stim_entry_t e;

        // Pop with every list empty.
        queue_request(MODE_POP, 5, 32'h1234_5678);
        // Extremes and a tie between lists three and five.
        queue_request(MODE_PUSH, 0, 32'h7FFF_FFFF);
        queue_request(MODE_PUSH, 7, 32'h8000_0000);
        queue_request(MODE_PUSH, 5, 32'hFFFF_FFFF);
        queue_request(MODE_PUSH, 3, 32'hFFFF_FFFF);
        queue_request(MODE_PUSH, 3, 32'h0000_0000);
        queue_request(MODE_PUSH, 1, 32'h0000_0001);
        repeat (7)
            queue_request(MODE_POP, $urandom_range(0, 7), $urandom);
        // One list in use: pushes beyond it are refused.
        queue_cfg(1);
        queue_request(MODE_PUSH, 1, 32'h0000_0005);
        queue_request(MODE_PUSH, 7, 32'h0000_0006);
        queue_request(MODE_PUSH, 0, 32'hFFFF_FFFB);
        // Zero acts as one list.
        queue_cfg(0);
        queue_request(MODE_PUSH, 1, 32'h0000_0007);
        // Fifteen acts as the maximum.
        queue_cfg(15);
        queue_request(MODE_PUSH, 7, 32'h0000_0009);
        queue_request(MODE_PUSH, 1, 32'h0000_000B);
        // Lists out of use keep their contents and count again later.
        queue_cfg(1);
        queue_request(MODE_POP, 0, 32'h0);
        queue_request(MODE_POP, 0, 32'h0);
        queue_cfg(8);
        queue_request(MODE_POP, 0, 32'h0);
        queue_request(MODE_POP, 0, 32'h0);

        // Random phases; pushes mostly keep each list ascending.
        cfg_plan   = '{2, 1, 8, 0, 15, 5, 9, 3, 8, 4};
        shared_val = $urandom_range(0, 200) - 100;
        for (int i = 0; i < MAX_LISTS; i++)
            run_val[i] = $urandom_range(0, 200) - 100;
        foreach (cfg_plan[p])
        begin
            queue_cfg(cfg_plan[p]);
            if (cfg_plan[p] == 0)
                gen_n = 1;
            else if (cfg_plan[p] > MAX_LISTS)
                gen_n = MAX_LISTS;
            else
                gen_n = cfg_plan[p];
            left = 105;
            while (left > 0)
            begin
                len = $urandom_range(1, 70);
                if (len > left)
                    len = left;
                push_pct = ($urandom_range(0, 1) == 1) ? 85 : 25;
                repeat (len)
                begin
                    if ($urandom_range(0, 99) < push_pct)
                    begin
                        k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7)
                                                         : $urandom_range(0, gen_n - 1);
                        if ($urandom_range(0, 15) == 0)
                            shared_val = $urandom_range(0, 200) - 100;
                        case ($urandom_range(0, 19))
                            0:       v = 32'h7FFF_FFFF;
                            1:       v = 32'h8000_0000;
                            2, 3:    v = $urandom;
                            4, 5, 6: v = 32'(shared_val);
                            default:
                            begin
                                run_val[k] += $urandom_range(0, 3);
                                v = 32'(run_val[k]);
                            end
                        endcase
                        queue_request(MODE_PUSH, k, v);
                    end
                    else
                        queue_request(MODE_POP, $urandom_range(0, 7), $urandom);
                end
                left -= len;
                // In the third phase the sender now and then holds off until all results are in.
                if (p == 2 && left > 0 && left < 60)
                begin
                    e.kind = ENTRY_DRAIN;
                    e.req  = '0;
                    e.cfg  = '0;
                    request_queue.push_back(e);
                end
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (request_queue.size() != 0 || start || cfg_valid || busy ||
               merge_results_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (merge_results_due.size() != 0)
            $display("%0d results never arrived", merge_results_due.size());
        if (mismatches == 0 && merge_results_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin : watchdog
        #(RUN_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

endmodule

/* k_way_merge_engine.f */
rtl/kwm_pkg.sv
rtl/kwm_ram.sv
rtl/kwm_min_tree.sv
rtl/k_way_merge_engine.sv
sim/testbench.sv
